// ----- src/hld_pkg.sv -----
package hld_pkg;

  // Leading characters of a line read as hex digits.
  localparam int HEX_DIGITS = 4;
  localparam int VAL_W      = 4 * HEX_DIGITS;
  localparam int CNT_W      = $clog2(HEX_DIGITS + 1);
  // Threshold width: nine times the top power of ten still fits.
  localparam int THR_W      = VAL_W + 4;

  function automatic int dec_digits(int h);
    longint v;
    int     n;
    v = (longint'(1) << (4 * h)) - 1;
    n = 1;
    while (v >= 10) begin
      v = v / 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int DEC_DIGITS = dec_digits(HEX_DIGITS);
  localparam int POS_W      = $clog2(DEC_DIGITS);

  // d * 10^k for every digit position k and digit d.
  typedef logic [9:0][THR_W-1:0]           thr_row_t;
  typedef thr_row_t [DEC_DIGITS-1:0]       thr_tab_t;

  function automatic thr_tab_t build_thr();
    thr_tab_t t;
    longint   p;
    p = 1;
    for (int k = 0; k < DEC_DIGITS; k++) begin
      for (int d = 0; d < 10; d++) begin
        t[k][d] = THR_W'(p * d);
      end
      p = p * 10;
    end
    return t;
  endfunction

  localparam thr_tab_t THR = build_thr();

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  typedef struct packed {
    logic accept;
    logic put_minus;
    logic put_one;
    logic step_digit;
    logic put_nl;
  } hld_cmd_t;

  typedef struct packed {
    logic close_line;   // request closes a non-empty line
    logic line_bad;     // that line gives "-1"
    logic slot_free;    // output register can take a byte this cycle
    logic pos_last;     // converting the units digit
  } hld_sts_t;

endpackage

// ----- src/hld_ctrl.sv -----
module hld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hld_pkg::hld_sts_t sts,
  output hld_pkg::hld_cmd_t cmd
);
  import hld_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MINUS = 5'b00010,
    S_ONE   = 5'b00100,
    S_DIGIT = 5'b01000,
    S_NL    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.close_line) begin
            state_nxt = sts.line_bad ? S_MINUS : S_DIGIT;
          end
        end
      end
      S_MINUS: begin
        if (sts.slot_free) begin
          cmd.put_minus = 1'b1;
          state_nxt     = S_ONE;
        end
      end
      S_ONE: begin
        if (sts.slot_free) begin
          cmd.put_one = 1'b1;
          state_nxt   = S_NL;
        end
      end
      S_DIGIT: begin
        if (sts.slot_free) begin
          cmd.step_digit = 1'b1;
          if (sts.pos_last) begin
            state_nxt = S_NL;
          end
        end
      end
      S_NL: begin
        if (sts.slot_free) begin
          cmd.put_nl = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("controller state not one-hot");

  a_close_starts_output: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.close_line) |=> (state_r == S_MINUS || state_r == S_DIGIT))
    else $error("closed line did not start output");

endmodule

// ----- src/hld_dp.sv -----
module hld_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_char_in,
  input  logic              in_end_of_file,
  input  hld_pkg::hld_cmd_t cmd,
  output hld_pkg::hld_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char_out,
  output logic              out_last_of_run
);
  import hld_pkg::*;

  // {ok, nibble}
  function automatic logic [4:0] hex_nib(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // line state
  logic [CNT_W-1:0] cnt_r;
  logic             inv_r;
  logic [VAL_W-1:0] hex_r;
  // conversion state
  logic [VAL_W-1:0] rem_r;
  logic [POS_W-1:0] pos_r;
  logic             started_r;
  // output register
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;

  logic             is_nl, close, count_in, nib_ok;
  logic [4:0]       nib_info;
  logic [3:0]       nib;
  logic [CNT_W-1:0] cnt_upd;
  logic             inv_upd;
  logic [VAL_W-1:0] hex_upd;
  logic [THR_W-1:0] rem_ext, sub;
  logic [3:0]       digit;
  logic             emit_digit, wr;
  logic [7:0]       wr_char;

  always_comb begin
    is_nl    = (in_char_in == CH_NL);
    close    = is_nl || in_end_of_file;
    nib_info = hex_nib(in_char_in);
    nib_ok   = nib_info[4];
    nib      = nib_info[3:0];
    count_in = !is_nl && (cnt_r < CNT_W'(HEX_DIGITS));
    cnt_upd  = count_in ? CNT_W'(cnt_r + 1'b1) : cnt_r;
    inv_upd  = inv_r || (count_in && !nib_ok);
    hex_upd  = (count_in && nib_ok) ? ((hex_r << 4) | VAL_W'(nib)) : hex_r;
  end

  // Digit at the current power of ten: nine parallel threshold compares.
  always_comb begin
    rem_ext = THR_W'(rem_r);
    digit   = '0;
    sub     = '0;
    for (int d = 1; d < 10; d++) begin
      if (rem_ext >= THR[pos_r][d]) begin
        digit = 4'(d);
        sub   = THR[pos_r][d];
      end
    end
  end

  always_comb begin
    sts.close_line = close && (cnt_upd != '0);
    sts.line_bad   = inv_upd || (cnt_upd < CNT_W'(HEX_DIGITS));
    sts.slot_free  = !out_valid_r || !out_stall;
    sts.pos_last   = (pos_r == '0);
    // leading zeros skipped, but a lone zero is still printed
    emit_digit     = (digit != '0) || started_r || sts.pos_last;
    wr = cmd.put_minus || cmd.put_one || cmd.put_nl || (cmd.step_digit && emit_digit);
    if (cmd.put_minus) begin
      wr_char = CH_MINUS;
    end else if (cmd.put_one) begin
      wr_char = CH_ONE;
    end else if (cmd.put_nl) begin
      wr_char = CH_NL;
    end else begin
      wr_char = CH_ZERO | {4'b0000, digit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      inv_r       <= 1'b0;
      hex_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (close) begin
          cnt_r <= '0;
          inv_r <= 1'b0;
          hex_r <= '0;
        end else begin
          cnt_r <= cnt_upd;
          inv_r <= inv_upd;
          hex_r <= hex_upd;
        end
      end
      if (wr) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && close) begin
      rem_r     <= hex_upd;
      pos_r     <= POS_W'(DEC_DIGITS - 1);
      started_r <= 1'b0;
    end else if (cmd.step_digit) begin
      rem_r     <= VAL_W'(rem_ext - sub);
      started_r <= started_r || emit_digit;
      if (!sts.pos_last) begin
        pos_r <= POS_W'(pos_r - 1'b1);
      end
    end
    if (wr) begin
      out_char_r <= wr_char;
      out_last_r <= cmd.put_nl;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_last_of_run = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HEX_DIGITS)) else $error("line character count overran");

  a_last_on_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_char_r == CH_NL)))
    else $error("run end flag not on newline");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !wr) else $error("output byte overwritten");

endmodule

// ----- src/hex_line_to_decimal_text.sv -----
// Hex line to decimal text converter. Bytes of text arrive on the in_ channel;
// for each non-empty line the first four characters are taken as a hex number
// and the block sends its decimal digits (no leading zeros) and a newline on the
// out_ channel, with out_last_of_run set on that newline. A line that is short
// or has a non-hex character among its first four gives "-1" and a newline.
// Characters after the fourth are dropped, empty lines give nothing, and a byte
// with in_end_of_file set closes the last line and clears all line state.
// An ordinary byte does not hold off the next request. A byte that closes a
// line holds it off while the line is written out: one step per decimal digit
// position (five, leading zeros included) plus one for the newline, or three
// steps for "-1", each held back by out_stall. The final newline sits in the
// output register while the next request is already taken.
module hex_line_to_decimal_text (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_last_of_run
);
  import hld_pkg::*;

  hld_cmd_t cmd;
  hld_sts_t sts;

  // Sequencer: byte intake, then "-1" or digit-by-digit output.
  hld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Line accumulator, power-of-ten digit extractor and output register.
  hld_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char_in      (in_char_in),
    .in_end_of_file  (in_end_of_file),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_last_of_run (out_last_of_run)
  );

endmodule
